// File: rtl/ptw_pkg.sv
package ptw_pkg;

	localparam int TABLE_PAGES = 16;
	localparam int ENTRIES_PER_TABLE = 512;
	localparam int IDX_W = 9;
	localparam int PAGE_W = $clog2(TABLE_PAGES);
	localparam int ADDR_W = PAGE_W + IDX_W;
	localparam int STORE_DEPTH = TABLE_PAGES * ENTRIES_PER_TABLE;

	localparam logic [63:0] ENTRY_ADDR_BITS = 64'h000F_FFFF_FFFF_F000;
	localparam logic [63:0] BIT_PRESENT = 64'h1;
	localparam logic [63:0] BIT_WRITE = 64'h2;
	localparam logic [63:0] BIT_USER = 64'h4;

	localparam logic OP_MAP = 1'b0;
	localparam logic OP_UNMAP = 1'b1;

	localparam logic [1:0] ST_DONE = 2'd0;
	localparam logic [1:0] ST_NO_PAGE = 2'd1;
	localparam logic [1:0] ST_UNMAPPED = 2'd2;
	localparam logic [1:0] ST_OUTSIDE = 2'd3;

	localparam logic CFG_ROOT_PAGE = 1'b0;
	localparam logic CFG_ALLOC_LIMIT = 1'b1;

	typedef struct packed {
		logic        opcode;
		logic [47:0] virtual_address;
		logic [51:0] physical_address;
		logic [63:0] page_flags;
	} req_t;

	typedef struct packed {
		logic [1:0] status;
		logic [1:0] stop_level;
		logic       invalidate;
		logic [1:0] tables_added;
	} rsp_t;

	// program steps
	localparam logic [3:0] P_IDLE   = 4'd0;
	localparam logic [3:0] P_ROOT   = 4'd1;
	localparam logic [3:0] P_READ   = 4'd2;
	localparam logic [3:0] P_EVAL   = 4'd3;
	localparam logic [3:0] P_LINK   = 4'd4;
	localparam logic [3:0] P_FOLLOW = 4'd5;
	localparam logic [3:0] P_MISS   = 4'd6;
	localparam logic [3:0] P_CLEAR  = 4'd7;
	localparam logic [3:0] P_ATTACH = 4'd8;
	localparam logic [3:0] P_LEAF   = 4'd9;
	localparam logic [3:0] P_DONE   = 4'd10;
	localparam logic [3:0] P_WIPE   = 4'd11;

	// datapath actions
	localparam logic [3:0] ACT_NONE   = 4'd0;
	localparam logic [3:0] ACT_START  = 4'd1;
	localparam logic [3:0] ACT_ROOT   = 4'd2;
	localparam logic [3:0] ACT_READ   = 4'd3;
	localparam logic [3:0] ACT_FOLLOW = 4'd4;
	localparam logic [3:0] ACT_MISS   = 4'd5;
	localparam logic [3:0] ACT_CLEAR  = 4'd6;
	localparam logic [3:0] ACT_ATTACH = 4'd7;
	localparam logic [3:0] ACT_LEAF   = 4'd8;
	localparam logic [3:0] ACT_DONE   = 4'd9;
	localparam logic [3:0] ACT_WIPE   = 4'd10;

	// branch conditions
	localparam logic [3:0] C_ALWAYS    = 4'd0;
	localparam logic [3:0] C_REQ       = 4'd1;
	localparam logic [3:0] C_ROOT_BAD  = 4'd2;
	localparam logic [3:0] C_LEAF      = 4'd3;
	localparam logic [3:0] C_PRESENT   = 4'd4;
	localparam logic [3:0] C_LINK_BAD  = 4'd5;
	localparam logic [3:0] C_MISS_FAIL = 4'd6;
	localparam logic [3:0] C_CLR_LAST  = 4'd7;
	localparam logic [3:0] C_OUT_FREE  = 4'd8;
	localparam logic [3:0] C_WIPE_LAST = 4'd9;

	typedef struct packed {
		logic [3:0] act;
		logic [3:0] cond;
		logic [3:0] jt;
		logic [3:0] jf;
	} uword_t;

	function automatic uword_t ucode(input logic [3:0] step);
		uword_t w;
		case (step)
			P_IDLE:   w = '{ACT_START,  C_REQ,       P_ROOT,   P_IDLE};
			P_ROOT:   w = '{ACT_ROOT,   C_ROOT_BAD,  P_DONE,   P_READ};
			P_READ:   w = '{ACT_READ,   C_ALWAYS,    P_EVAL,   P_EVAL};
			P_EVAL:   w = '{ACT_NONE,   C_LEAF,      P_LEAF,   P_LINK};
			P_LINK:   w = '{ACT_NONE,   C_PRESENT,   P_FOLLOW, P_MISS};
			P_FOLLOW: w = '{ACT_FOLLOW, C_LINK_BAD,  P_DONE,   P_READ};
			P_MISS:   w = '{ACT_MISS,   C_MISS_FAIL, P_DONE,   P_CLEAR};
			P_CLEAR:  w = '{ACT_CLEAR,  C_CLR_LAST,  P_ATTACH, P_CLEAR};
			P_ATTACH: w = '{ACT_ATTACH, C_ALWAYS,    P_READ,   P_READ};
			P_LEAF:   w = '{ACT_LEAF,   C_ALWAYS,    P_DONE,   P_DONE};
			P_DONE:   w = '{ACT_DONE,   C_OUT_FREE,  P_IDLE,   P_DONE};
			P_WIPE:   w = '{ACT_WIPE,   C_WIPE_LAST, P_IDLE,   P_WIPE};
			default:  w = '{ACT_NONE,   C_ALWAYS,    P_IDLE,   P_IDLE};
		endcase
		return w;
	endfunction

endpackage

// File: rtl/page_table_map_unmap_walker.sv
// Walk steps: after acceptance a root check, then per link level a read, an evaluate, a
// present test and a follow, and at the leaf level a read, an evaluate, the leaf write
// and the response load; early stops go straight to the response load. Each table page
// allocated adds a miss step and a 512-entry clear of the new page. One request at a
// time: req_stall drops in the cycle after the response loads, even while it is stalled.
// Reset: async, active low; the 8192-entry store is then cleared before the first request.
module page_table_map_unmap_walker (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_stall,
	input  ptw_pkg::req_t        req,
	output logic                 rsp_valid,
	input  logic                 rsp_stall,
	output ptw_pkg::rsp_t        rsp,
	input  logic                 cfg_we,
	input  logic                 cfg_index,
	input  logic [4:0]           cfg_data
);

	logic [63:0] mem [ptw_pkg::STORE_DEPTH];

	logic [3:0]                   upc_q;
	logic [3:0]                   root_page_q;
	logic [4:0]                   alloc_limit_q;
	logic [4:0]                   next_free_q;
	logic [ptw_pkg::ADDR_W-1:0]   wipe_q;
	logic [ptw_pkg::IDX_W-1:0]    clr_q;
	logic [ptw_pkg::PAGE_W-1:0]   page_q;
	logic [ptw_pkg::PAGE_W-1:0]   new_page_q;
	logic [1:0]                   level_q;
	logic [1:0]                   status_q;
	logic                         inval_q;
	logic [1:0]                   added_q;
	ptw_pkg::req_t                req_q;
	logic [63:0]                  rd_q;
	logic                         out_valid_q;
	ptw_pkg::rsp_t                out_q;

	ptw_pkg::uword_t              uw;
	logic                         accept;
	logic                         out_free;
	logic                         take;
	logic [ptw_pkg::IDX_W-1:0]    idx;
	logic [ptw_pkg::ADDR_W-1:0]   walk_addr;
	logic                         present;
	logic                         root_bad;
	logic                         link_bad;
	logic                         unmap;
	logic                         no_page;
	logic                         wr_en;
	logic [ptw_pkg::ADDR_W-1:0]   wr_addr;
	logic [63:0]                  wr_data;

	assign uw = ptw_pkg::ucode(upc_q);
	assign req_stall = (upc_q != ptw_pkg::P_IDLE);
	assign accept = req_valid && !req_stall;
	assign out_free = !out_valid_q || !rsp_stall;
	assign rsp_valid = out_valid_q;
	assign rsp = out_q;

	always_comb begin
		case (level_q)
			2'd0:    idx = req_q.virtual_address[47:39];
			2'd1:    idx = req_q.virtual_address[38:30];
			2'd2:    idx = req_q.virtual_address[29:21];
			default: idx = req_q.virtual_address[20:12];
		endcase
	end

	assign walk_addr = {page_q, idx};
	assign present = rd_q[0];
	assign unmap = (req_q.opcode == ptw_pkg::OP_UNMAP);
	assign root_bad = 32'(root_page_q) >= ptw_pkg::TABLE_PAGES;
	assign link_bad = rd_q[51:12] >= 40'(ptw_pkg::TABLE_PAGES);
	assign no_page = (next_free_q >= alloc_limit_q) ||
		(32'(next_free_q) >= ptw_pkg::TABLE_PAGES);

	always_comb begin
		case (uw.cond)
			ptw_pkg::C_ALWAYS:    take = 1'b1;
			ptw_pkg::C_REQ:       take = accept;
			ptw_pkg::C_ROOT_BAD:  take = root_bad;
			ptw_pkg::C_LEAF:      take = (level_q == 2'd3);
			ptw_pkg::C_PRESENT:   take = present;
			ptw_pkg::C_LINK_BAD:  take = link_bad;
			ptw_pkg::C_MISS_FAIL: take = unmap || no_page;
			ptw_pkg::C_CLR_LAST:  take = (clr_q == '1);
			ptw_pkg::C_OUT_FREE:  take = out_free;
			ptw_pkg::C_WIPE_LAST: take = (wipe_q == ptw_pkg::ADDR_W'(ptw_pkg::STORE_DEPTH - 1));
			default:              take = 1'b0;
		endcase
	end

	always_comb begin
		wr_en = 1'b0;
		wr_addr = walk_addr;
		wr_data = '0;
		case (uw.act)
			ptw_pkg::ACT_CLEAR: begin
				wr_en = 1'b1;
				wr_addr = {new_page_q, clr_q};
			end
			ptw_pkg::ACT_ATTACH: begin
				wr_en = 1'b1;
				wr_data = (64'(new_page_q) << 12) | ptw_pkg::BIT_PRESENT |
					ptw_pkg::BIT_WRITE | (req_q.page_flags & ptw_pkg::BIT_USER);
			end
			ptw_pkg::ACT_LEAF: begin
				wr_en = !(unmap && !present);
				wr_data = unmap ? 64'd0 :
					(({12'd0, req_q.physical_address} & ptw_pkg::ENTRY_ADDR_BITS) |
					req_q.page_flags | ptw_pkg::BIT_PRESENT);
			end
			ptw_pkg::ACT_WIPE: begin
				wr_en = 1'b1;
				wr_addr = wipe_q;
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (uw.act == ptw_pkg::ACT_READ) begin
			rd_q <= mem[walk_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q <= ptw_pkg::P_WIPE;
			root_page_q <= '0;
			alloc_limit_q <= 5'd16;
			next_free_q <= 5'd1;
			wipe_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			upc_q <= take ? uw.jt : uw.jf;
			if (cfg_we) begin
				case (cfg_index)
					ptw_pkg::CFG_ROOT_PAGE:   root_page_q <= cfg_data[3:0];
					ptw_pkg::CFG_ALLOC_LIMIT: alloc_limit_q <= cfg_data;
					default:                  root_page_q <= root_page_q;
				endcase
			end
			if (uw.act == ptw_pkg::ACT_WIPE) begin
				wipe_q <= wipe_q + 1'b1;
			end
			if (uw.act == ptw_pkg::ACT_MISS && !unmap && !no_page) begin
				next_free_q <= next_free_q + 5'd1;
			end
			if (uw.act == ptw_pkg::ACT_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (uw.act)
			ptw_pkg::ACT_START: begin
				if (accept) begin
					req_q <= req;
					level_q <= 2'd0;
					page_q <= ptw_pkg::PAGE_W'(root_page_q);
					status_q <= ptw_pkg::ST_DONE;
					inval_q <= 1'b0;
					added_q <= 2'd0;
				end
			end
			ptw_pkg::ACT_ROOT: begin
				if (root_bad) begin
					status_q <= ptw_pkg::ST_OUTSIDE;
				end
			end
			ptw_pkg::ACT_FOLLOW: begin
				if (link_bad) begin
					status_q <= ptw_pkg::ST_OUTSIDE;
				end else begin
					page_q <= ptw_pkg::PAGE_W'(rd_q[51:12]);
					level_q <= level_q + 2'd1;
				end
			end
			ptw_pkg::ACT_MISS: begin
				if (unmap) begin
					status_q <= ptw_pkg::ST_UNMAPPED;
				end else if (no_page) begin
					status_q <= ptw_pkg::ST_NO_PAGE;
				end else begin
					new_page_q <= ptw_pkg::PAGE_W'(next_free_q);
					added_q <= added_q + 2'd1;
					clr_q <= '0;
				end
			end
			ptw_pkg::ACT_CLEAR: begin
				clr_q <= clr_q + 1'b1;
			end
			ptw_pkg::ACT_ATTACH: begin
				page_q <= new_page_q;
				level_q <= level_q + 2'd1;
			end
			ptw_pkg::ACT_LEAF: begin
				if (unmap && !present) begin
					status_q <= ptw_pkg::ST_UNMAPPED;
				end else begin
					inval_q <= 1'b1;
				end
			end
			ptw_pkg::ACT_DONE: begin
				if (out_free) begin
					out_q.status <= status_q;
					out_q.stop_level <= level_q;
					out_q.invalidate <= inval_q;
					out_q.tables_added <= added_q;
				end
			end
			default: begin
				status_q <= status_q;
			end
		endcase
	end

endmodule

// File: verif/ptw_checker.sv
`timescale 1ns / 100ps

module ptw_checker
	import ptw_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	input  logic       req_stall,
	input  req_t       req,
	input  logic       rsp_valid,
	input  logic       rsp_stall,
	input  rsp_t       rsp,
	input  logic       cfg_we,
	input  logic       cfg_index,
	input  logic [4:0] cfg_data,
	input  logic       end_of_run,
	output int         errors
);

	logic [63:0] table_mem [STORE_DEPTH];
	logic [4:0]  next_free;
	logic [3:0]  root_page;
	logic [4:0]  alloc_limit;
	rsp_t        walk_results_q[$];
	bit          end_seen;

	initial errors = 0;

	task automatic flag_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		if (errors < 100)
			$display("%0t: %s: got %0h, expected %0h", $time, what, got, want);
		errors++;
	endtask

	function automatic void reset_tables();
		foreach (table_mem[i])
			table_mem[i] = '0;
		next_free = 5'd1;
		root_page = '0;
		alloc_limit = 5'd16;
		walk_results_q.delete();
	endfunction

	// walks the table for one request, updating the store as the block would
	function automatic rsp_t walk_table(input req_t r);
		rsp_t        o;
		logic [63:0] pg;
		logic [63:0] tgt;
		logic [63:0] fresh;
		logic [8:0]  idx;
		int unsigned slot;
		int          lvl;
		o = '0;
		pg = 64'(root_page);
		if (pg >= TABLE_PAGES) begin
			o.status = ST_OUTSIDE;
			return o;
		end
		for (lvl = 0; lvl < 3; lvl++) begin
			o.stop_level = 2'(lvl);
			idx = 9'(r.virtual_address >> (39 - 9 * lvl));
			slot = int'(pg) * ENTRIES_PER_TABLE + idx;
			if (!table_mem[slot][0]) begin
				if (r.opcode == OP_UNMAP) begin
					o.status = ST_UNMAPPED;
					return o;
				end
				if (next_free >= alloc_limit || next_free >= TABLE_PAGES) begin
					o.status = ST_NO_PAGE;
					return o;
				end
				fresh = 64'(next_free);
				next_free = next_free + 5'd1;
				for (int k = 0; k < ENTRIES_PER_TABLE; k++)
					table_mem[int'(fresh) * ENTRIES_PER_TABLE + k] = '0;
				o.tables_added = o.tables_added + 2'd1;
				table_mem[slot] = (fresh << 12) | BIT_PRESENT | BIT_WRITE
					| (r.page_flags & BIT_USER);
			end
			tgt = (table_mem[slot] & ENTRY_ADDR_BITS) >> 12;
			if (tgt >= TABLE_PAGES) begin
				o.status = ST_OUTSIDE;
				return o;
			end
			pg = tgt;
		end
		o.stop_level = 2'd3;
		idx = r.virtual_address[20:12];
		slot = int'(pg) * ENTRIES_PER_TABLE + idx;
		if (r.opcode == OP_UNMAP) begin
			if (!table_mem[slot][0]) begin
				o.status = ST_UNMAPPED;
				return o;
			end
			table_mem[slot] = '0;
		end else begin
			table_mem[slot] = ({12'b0, r.physical_address} & ENTRY_ADDR_BITS)
				| r.page_flags | BIT_PRESENT;
		end
		o.invalidate = 1'b1;
		return o;
	endfunction

	always @(posedge clk) begin
		rsp_t want;
		if (!arst_n) begin
			reset_tables();
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_ROOT_PAGE:   root_page = cfg_data[3:0];
					CFG_ALLOC_LIMIT: alloc_limit = cfg_data;
				endcase
			end
			if (req_valid && !req_stall)
				walk_results_q.push_back(walk_table(req));
			if (rsp_valid && !rsp_stall) begin
				if (walk_results_q.size() == 0) begin
					flag_mismatch("response with no request pending", 64'(rsp), '0);
				end else begin
					want = walk_results_q.pop_front();
					if (rsp.status !== want.status)
						flag_mismatch("status", 64'(rsp.status), 64'(want.status));
					if (rsp.stop_level !== want.stop_level)
						flag_mismatch("stop_level", 64'(rsp.stop_level),
							64'(want.stop_level));
					if (rsp.invalidate !== want.invalidate)
						flag_mismatch("invalidate", 64'(rsp.invalidate),
							64'(want.invalidate));
					if (rsp.tables_added !== want.tables_added)
						flag_mismatch("tables_added", 64'(rsp.tables_added),
							64'(want.tables_added));
				end
			end
			if (end_of_run && !end_seen) begin
				end_seen = 1'b1;
				if (walk_results_q.size() != 0)
					flag_mismatch("responses missing at end", 64'(walk_results_q.size()),
						'0);
			end
		end
	end

endmodule

// File: verif/testbench.sv
`timescale 1ns / 100ps

module testbench;
	import ptw_pkg::*;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       req_valid = 1'b0;
	logic       req_stall;
	req_t       req = '0;
	logic       rsp_valid;
	logic       rsp_stall = 1'b0;
	rsp_t       rsp;
	logic       cfg_we = 1'b0;
	logic       cfg_index = CFG_ROOT_PAGE;
	logic [4:0] cfg_data = '0;
	logic       end_of_run = 1'b0;
	int         errors;
	int         n_sent = 0;
	int         n_rcvd = 0;
	int         burst_left = 0;
	int         stall_left = 0;
	int         stall_mode = 0;

	page_table_map_unmap_walker dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	ptw_checker chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.req        (req),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.rsp        (rsp),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.end_of_run (end_of_run),
		.errors     (errors)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#50_000_000;
		$display("FAIL");
		$finish;
	end

	// receiver: free-flowing, choppy and mostly-stalled stretches
	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_mode <= $urandom_range(0, 2);
			stall_left <= $urandom_range(20, 200);
		end else begin
			stall_left <= stall_left - 1;
		end
		case (stall_mode)
			0:       rsp_stall <= 1'b0;
			1:       rsp_stall <= 1'($urandom_range(0, 1));
			default: rsp_stall <= ($urandom_range(0, 7) != 0);
		endcase
	end

	always @(posedge clk) begin
		if (rsp_valid && !rsp_stall)
			n_rcvd <= n_rcvd + 1;
	end

	function automatic logic [47:0] va_of(input logic [8:0] a, input logic [8:0] b,
			input logic [8:0] c, input logic [8:0] d);
		return {a, b, c, d, 12'($urandom)};
	endfunction

	function automatic req_t make_req(input logic op, input logic [47:0] va,
			input logic [51:0] pa, input logic [63:0] flags);
		req_t r;
		r.opcode = op;
		r.virtual_address = va;
		r.physical_address = pa;
		r.page_flags = flags;
		return r;
	endfunction

	// indices drawn from small sets so walks reuse the few table pages there are
	function automatic req_t random_request();
		req_t       r;
		logic [8:0] i0, i1, i2, i3;
		i0 = $urandom_range(0, 1) ? 9'h1FF : 9'h000;
		case ($urandom_range(0, 2))
			0:       i1 = 9'h000;
			1:       i1 = 9'h001;
			default: i1 = 9'h1FF;
		endcase
		i2 = $urandom_range(0, 1) ? 9'h1FF : 9'h000;
		case ($urandom_range(0, 4))
			0:       i3 = 9'h000;
			1:       i3 = 9'h001;
			2:       i3 = 9'h1FF;
			default: i3 = 9'($urandom);
		endcase
		r.opcode = ($urandom_range(0, 9) < 6) ? OP_MAP : OP_UNMAP;
		r.virtual_address = ($urandom_range(0, 9) == 0) ? 48'({$urandom, $urandom})
			: va_of(i0, i1, i2, i3);
		r.physical_address = ($urandom_range(0, 2) == 0)
			? 52'($urandom_range(0, TABLE_PAGES * 4096 - 1)) : 52'({$urandom, $urandom});
		r.page_flags = {$urandom, $urandom};
		return r;
	endfunction

	task automatic send(input req_t r);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
			if (gap > 0) begin
				req_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 8);
		end
		burst_left--;
		req <= r;
		req_valid <= 1'b1;
		do @(posedge clk); while (req_stall);
		n_sent++;
	endtask

	task automatic set_config(input logic [3:0] root, input logic [4:0] limit);
		req_valid <= 1'b0;
		while (n_rcvd != n_sent) @(posedge clk);
		repeat (4) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= CFG_ROOT_PAGE;
		cfg_data <= {1'b0, root};
		@(posedge clk);
		cfg_index <= CFG_ALLOC_LIMIT;
		cfg_data <= limit;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		set_config(4'd0, 5'd16);
		send(make_req(OP_MAP, va_of(9'd0, 9'd0, 9'd0, 9'd0), '1, '1));
		send(make_req(OP_MAP, va_of(9'd0, 9'd0, 9'd0, 9'd0), '0, '0));
		send(make_req(OP_UNMAP, va_of(9'd0, 9'd0, 9'd0, 9'd0), '1, '1));
		send(make_req(OP_UNMAP, va_of(9'd0, 9'd0, 9'd0, 9'd0), '0, '0));
		send(make_req(OP_UNMAP, va_of(9'h1FF, 9'd0, 9'd0, 9'd0), '0, '0));
		send(make_req(OP_UNMAP, va_of(9'd0, 9'h1FF, 9'd0, 9'd0), '0, '0));
		send(make_req(OP_UNMAP, va_of(9'd0, 9'd0, 9'h1FF, 9'd0), '0, '0));
		send(make_req(OP_MAP, '1, '1, '0));
		// allocator runs dry at the first and then the second missing level
		set_config(4'd0, 5'd7);
		send(make_req(OP_MAP, va_of(9'd0, 9'd1, 9'd0, 9'd5), 52'h12345, 64'h4));
		set_config(4'd0, 5'd8);
		send(make_req(OP_MAP, va_of(9'd0, 9'd1, 9'd0, 9'd5), 52'h12345, 64'h4));
		set_config(4'd0, 5'd0);
		send(make_req(OP_MAP, va_of(9'd5, 9'd0, 9'd0, 9'd0), '0, '0));
		// root is the next page handed out, so it gets cleared under the walk
		set_config(4'd8, 5'd16);
		send(make_req(OP_MAP, va_of(9'd0, 9'd0, 9'd0, 9'd0), 52'h3000, 64'h4));
		// a leaf table as root: its leaf entries point outside the store
		set_config(4'd6, 5'd16);
		send(make_req(OP_MAP, va_of(9'h1FF, 9'd0, 9'd0, 9'd0), '0, '0));
		send(make_req(OP_UNMAP, va_of(9'h1FF, 9'd0, 9'd0, 9'd0), '0, '0));
		set_config(4'd15, 5'd16);
		send(make_req(OP_UNMAP, va_of(9'd0, 9'd0, 9'd0, 9'd0), '0, '0));
		send(make_req(OP_MAP, va_of(9'd0, 9'd0, 9'd0, 9'd1), '1, '1));

		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0:       set_config(4'd0, 5'd16);
				1:       set_config(4'd0, 5'($urandom_range(1, 16)));
				2:       set_config(4'($urandom_range(0, 15)), 5'd16);
				3:       set_config(4'd0, 5'd1);
				4:       set_config(4'd15, 5'd31);
				default: set_config(4'd0, 5'd16);
			endcase
			for (int n = 0; n < 59; n++)
				send(random_request());
		end

		req_valid <= 1'b0;
		while (n_rcvd != n_sent) @(posedge clk);
		repeat (20) @(posedge clk);
		end_of_run <= 1'b1;
		repeat (3) @(posedge clk);
		@(negedge clk);
		if (errors == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
